@@ hw/rtl/i2cbm_pkg.sv @@
`timescale 1ns / 1ps
// i2cbm_pkg: shared types and constants for the i2c bit master
// used by the step logic, the top level and the port checker

package i2cbm_pkg;

    // bus commands carried with each tick
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // sequencer step to run when the current wait ends, idle when none
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_1    = 3'd1,
        PH_2    = 3'd2,
        PH_3    = 3'd3,
        PH_4    = 3'd4,
        PH_5    = 3'd5,
        PH_6    = 3'd6,
        PH_7    = 3'd7
    } phase_t;

    // configuration register indexes
    localparam logic REG_SHORT_DELAY = 1'b0;
    localparam logic REG_LONG_DELAY  = 1'b1;

    // bits moved per byte transfer
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // payload widths on the stream ports
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // sequencer state apart from the delay counter
    typedef struct packed {
        phase_t      phase;
        op_t         aop;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift;
        logic        scl;
        logic        drive;
        logic        level;
        logic        ack;
        logic        wait_long;
        logic [7:0]  read_hold;
    } seq_state_t;

endpackage

@@ hw/rtl/i2c_bit_master_unit.sv @@
`timescale 1ns / 1ps
// i2c_bit_master_unit: top level of the tick-driven i2c bit master
// depends on i2cbm_pkg and i2cbm_step
//
// Usage:
//   The s_axis channel carries one timebase tick per transaction: a command
//   flag, the operation (start, stop, write byte, read byte), the byte to
//   write and the sampled sda level. Every accepted tick yields exactly one
//   m_axis transaction with the pin levels, busy, done, ack flag and the
//   last read byte, as they stand after that tick.
//   The result is registered and is on m_axis in the cycle after acceptance;
//   a new tick is taken every cycle unless m_axis stalls, the rate being set
//   by the single step of the sequencer between its state registers and the
//   output register. A command is taken only while idle; ticks during a
//   command still step the delay counter and the pin sequence. The delay
//   registers are written through cfg_we/cfg_addr/cfg_wdata, index 0 short
//   delay, index 1 long delay; the user must write them only while no command
//   is running (unchecked by the block). Reset puts the lines at scl high, sda
//   driven high, clears the state, loads delays of 2 and 4 ticks and empties
//   the output register. When m_axis_tready is low with a result held,
//   s_axis_tready drops and the sequencer holds until the result is taken.

module i2c_bit_master_unit #(
    parameter int DELAY_WIDTH = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // tick input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] command_valid, [2:1] operation, [10:3] write_data, [11] sda_sense
    input  logic [i2cbm_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] scl_level, [1] sda_drive, [2] sda_level, [3] busy_res,
    // [4] done_res, [5] ack_missing, [13:6] read_data
    output logic [i2cbm_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // configuration writes
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [DELAY_WIDTH-1:0]            cfg_wdata
);
    import i2cbm_pkg::*;

    localparam logic [DELAY_WIDTH-1:0] SHORT_RESET = DELAY_WIDTH'(2);
    localparam logic [DELAY_WIDTH-1:0] LONG_RESET  = DELAY_WIDTH'(4);

    seq_state_t               st_reg;
    seq_state_t               st_next;
    logic [DELAY_WIDTH-1:0]   cnt_reg;
    logic [DELAY_WIDTH-1:0]   cnt_next;
    logic [DELAY_WIDTH-1:0]   short_delay_reg;
    logic [DELAY_WIDTH-1:0]   long_delay_reg;
    logic                     out_valid_reg;
    logic [M_TDATA_W-1:0]     out_data_reg;
    logic                     done;
    logic                     accept;

    // take a tick whenever the output register is free or being emptied
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    i2cbm_step #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_step (
        .cur         (st_reg),
        .cnt         (cnt_reg),
        .short_delay (short_delay_reg),
        .long_delay  (long_delay_reg),
        .cmd_valid   (s_axis_tdata[0]),
        .cmd_op      (op_t'(s_axis_tdata[2:1])),
        .wdata       (s_axis_tdata[10:3]),
        .sense       (s_axis_tdata[11]),
        .nxt         (st_next),
        .cnt_next    (cnt_next),
        .done        (done)
    );

    // delay configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_delay_reg <= SHORT_RESET;
            long_delay_reg  <= LONG_RESET;
        end else if (cfg_we) begin
            if (cfg_addr == REG_SHORT_DELAY) begin
                short_delay_reg <= cfg_wdata;
            end
            if (cfg_addr == REG_LONG_DELAY) begin
                long_delay_reg <= cfg_wdata;
            end
        end
    end

    // sequencer state advances once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase     <= PH_IDLE;
            st_reg.aop       <= OP_START;
            st_reg.bit_cnt   <= '0;
            st_reg.shift     <= '0;
            st_reg.scl       <= 1'b1;
            st_reg.drive     <= 1'b1;
            st_reg.level     <= 1'b1;
            st_reg.ack       <= 1'b0;
            st_reg.wait_long <= 1'b0;
            st_reg.read_hold <= '0;
            cnt_reg          <= '0;
        end else if (accept) begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    // output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {2'b00, st_next.read_hold, st_next.ack, done,
                             (st_next.phase != PH_IDLE), st_next.level,
                             st_next.drive, st_next.scl};
        end
    end

endmodule

@@ hw/rtl/i2cbm_step.sv @@
`timescale 1ns / 1ps
// i2cbm_step: next-state logic of the i2c bit sequencer for one tick
// depends on i2cbm_pkg

module i2cbm_step #(
    parameter int DELAY_WIDTH = 12
) (
    input  i2cbm_pkg::seq_state_t   cur,
    input  logic [DELAY_WIDTH-1:0]  cnt,
    input  logic [DELAY_WIDTH-1:0]  short_delay,
    input  logic [DELAY_WIDTH-1:0]  long_delay,
    input  logic                    cmd_valid,
    input  i2cbm_pkg::op_t          cmd_op,
    input  logic [7:0]              wdata,
    input  logic                    sense,
    output i2cbm_pkg::seq_state_t   nxt,
    output logic [DELAY_WIDTH-1:0]  cnt_next,
    output logic                    done
);
    import i2cbm_pkg::*;

    localparam logic [DELAY_WIDTH-1:0] CNT_MAX = {DELAY_WIDTH{1'b1}};

    always_comb begin
        phase_t                 step;
        logic                   run;
        logic                   skip;
        logic                   w_set;
        logic                   w_long;
        phase_t                 w_next;
        logic                   fin;
        logic [DELAY_WIDTH-1:0] cnt_inc;
        logic [DELAY_WIDTH-1:0] tgt;

        nxt      = cur;
        cnt_next = cnt;
        step     = cur.phase;
        run      = 1'b0;
        skip     = 1'b0;
        w_set    = 1'b0;
        w_long   = 1'b0;
        w_next   = PH_IDLE;
        fin      = 1'b0;
        cnt_inc  = cnt;
        tgt      = short_delay;

        // idle: a command starts its first step on this tick
        // busy: count the wait, saturating, and step when it reaches the target
        if (cur.phase == PH_IDLE) begin
            if (cmd_valid) begin
                nxt.aop = cmd_op;
                run     = 1'b1;
            end
        end else begin
            cnt_inc  = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
            cnt_next = cnt_inc;
            tgt      = cur.wait_long ? long_delay : short_delay;
            run      = (cnt_inc >= tgt);
        end

        if (run) begin
            case (nxt.aop)
                // start condition: sda falls while scl high, then scl low
                OP_START: begin
                    case (step)
                        PH_IDLE: begin
                            w_set = 1'b1; w_long = 1'b1; w_next = PH_1;
                        end
                        PH_1: begin
                            nxt.level = 1'b0;
                            w_set = 1'b1; w_long = 1'b1; w_next = PH_2;
                        end
                        PH_2: begin
                            nxt.scl = 1'b0;
                            w_set = 1'b1; w_long = 1'b0; w_next = PH_3;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                // stop condition: sda low, scl high, then sda high
                OP_STOP: begin
                    case (step)
                        PH_IDLE: begin
                            nxt.level = 1'b0;
                            w_set = 1'b1; w_long = 1'b0; w_next = PH_1;
                        end
                        PH_1: begin
                            nxt.scl = 1'b1;
                            w_set = 1'b1; w_long = 1'b1; w_next = PH_2;
                        end
                        PH_2: begin
                            nxt.level = 1'b1;
                            w_set = 1'b1; w_long = 1'b1; w_next = PH_3;
                        end
                        default: fin = 1'b1;
                    endcase
                end
                // write byte msb first, then release sda and sample the ack
                OP_WRITE: begin
                    if (step == PH_IDLE) begin
                        nxt.bit_cnt = '0;
                        nxt.shift   = wdata;
                        step        = PH_1;
                    end
                    if (step == PH_3) begin
                        nxt.scl     = 1'b0;
                        nxt.bit_cnt = nxt.bit_cnt + 4'd1;
                        if (nxt.bit_cnt < BITS_PER_BYTE) begin
                            step = PH_1;
                        end else begin
                            nxt.drive = 1'b0;
                            nxt.level = 1'b1;
                            w_set = 1'b1; w_long = 1'b0; w_next = PH_4;
                            skip  = 1'b1;
                        end
                    end
                    if (!skip) begin
                        case (step)
                            PH_1: begin
                                nxt.drive = 1'b1;
                                nxt.level = nxt.shift[7];
                                nxt.shift = {nxt.shift[6:0], 1'b0};
                                w_set = 1'b1; w_long = 1'b0; w_next = PH_2;
                            end
                            PH_2: begin
                                nxt.scl = 1'b1;
                                w_set = 1'b1; w_long = 1'b0; w_next = PH_3;
                            end
                            PH_4: begin
                                nxt.scl = 1'b1;
                                w_set = 1'b1; w_long = 1'b1; w_next = PH_5;
                            end
                            PH_5: begin
                                nxt.ack = sense;
                                w_set = 1'b1; w_long = 1'b1; w_next = PH_6;
                            end
                            PH_6: begin
                                nxt.scl = 1'b0;
                                w_set = 1'b1; w_long = 1'b0; w_next = PH_7;
                            end
                            default: begin
                                nxt.drive = 1'b1;
                                fin       = 1'b1;
                            end
                        endcase
                    end
                end
                // read byte msb first, then answer with ack (sda low)
                default: begin
                    case (step)
                        PH_IDLE: begin
                            nxt.drive   = 1'b0;
                            nxt.bit_cnt = '0;
                            nxt.shift   = '0;
                            w_set = 1'b1; w_long = 1'b0; w_next = PH_1;
                        end
                        PH_1: begin
                            nxt.scl = 1'b1;
                            w_set = 1'b1; w_long = 1'b1; w_next = PH_2;
                        end
                        PH_2: begin
                            nxt.shift = {nxt.shift[6:0], sense};
                            w_set = 1'b1; w_long = 1'b1; w_next = PH_3;
                        end
                        PH_3: begin
                            nxt.scl     = 1'b0;
                            nxt.bit_cnt = nxt.bit_cnt + 4'd1;
                            w_set       = 1'b1;
                            w_long      = 1'b0;
                            if (nxt.bit_cnt < BITS_PER_BYTE) begin
                                w_next = PH_1;
                            end else begin
                                nxt.drive = 1'b1;
                                nxt.level = 1'b0;
                                w_next    = PH_4;
                            end
                        end
                        PH_4: begin
                            nxt.scl = 1'b1;
                            w_set = 1'b1; w_long = 1'b0; w_next = PH_5;
                        end
                        default: begin
                            nxt.scl       = 1'b0;
                            nxt.level     = 1'b1;
                            nxt.read_hold = nxt.shift;
                            fin           = 1'b1;
                        end
                    endcase
                end
            endcase
        end

        // start the next wait or return to idle
        if (w_set) begin
            nxt.wait_long = w_long;
            nxt.phase     = w_next;
            cnt_next      = '0;
        end
        if (fin) begin
            nxt.phase = PH_IDLE;
        end
        done = fin;
    end

endmodule

@@ hw/rtl/i2cbm_checker.sv @@
`timescale 1ns / 1ps
// i2cbm_port_checker: port-level assertions for the i2c bit master
// depends on i2cbm_pkg; bound to i2c_bit_master_unit below

module i2cbm_port_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [i2cbm_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import i2cbm_pkg::*;

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // no tick is taken while a result waits
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("tick accepted while output stalled");

    // a finishing command is never reported busy
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]))
        else $error("done and busy together");

    // each accepted tick produces a result in the next cycle
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted tick gave no result");

    // output register is empty after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind i2c_bit_master_unit i2cbm_port_checker u_i2cbm_checker (.*);

@@ verif/i2cbm_checker.sv @@
`timescale 1ns / 1ps
// i2cbm_checker: watches the tick and result streams of the i2c bit master,
// predicts pin and status words per accepted tick and compares them (uses i2cbm_pkg)

module i2cbm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [0] command_valid, [2:1] operation, [10:3] write_data, [11] sda_sense
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_level, [1] sda_drive, [2] sda_level, [3] busy_res,
    // [4] done_res, [5] ack_missing, [13:6] read_data
    input  logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata,
    output logic        busy_next,
    output int          pending,
    output int          fail_count
);
    import i2cbm_pkg::*;

    localparam logic [11:0] DLY_MAX = 12'hFFF;

    // predicted sequencer state, updated on each accepted tick
    typedef struct packed {
        phase_t      ph;
        op_t         aop;
        logic [11:0] cnt;
        logic [3:0]  bits;
        logic [7:0]  shift;
        logic        scl;
        logic        drive;
        logic        level;
        logic        ack;
        logic        wlong;
        logic [7:0]  rd_hold;
        logic        done;
    } bus_state_t;

    // status word as it leaves the block
    typedef struct packed {
        logic [7:0] rd;
        logic       ack;
        logic       done;
        logic       busy;
        logic       level;
        logic       drive;
        logic       scl;
    } pin_word_t;

    localparam bus_state_t BUS_RESET = '{
        ph: PH_IDLE, aop: OP_START, cnt: '0, bits: '0, shift: '0,
        scl: 1'b1, drive: 1'b1, level: 1'b1, ack: 1'b0, wlong: 1'b0,
        rd_hold: '0, done: 1'b0
    };

    bus_state_t  bus_st;
    bus_state_t  step_nxt;
    logic [11:0] short_dly;
    logic [11:0] long_dly;
    pin_word_t   expected_pins_q[$];
    logic        s_hs;

    initial fail_count = 0;

    // arm a wait and name the step that runs when it ends
    function automatic bus_state_t arm_wait(bus_state_t s, logic lng, phase_t nxt);
        s.wlong = lng;
        s.cnt   = '0;
        s.ph    = nxt;
        return s;
    endfunction

    function automatic bus_state_t end_cmd(bus_state_t s);
        s.ph   = PH_IDLE;
        s.done = 1'b1;
        return s;
    endfunction

    // pin actions of one step, up to the next wait or the end of the command
    function automatic bus_state_t run_pin_step(bus_state_t s, phase_t step_in,
                                                logic sense, logic [7:0] wd);
        phase_t step;
        step = step_in;
        case (s.aop)
            OP_START: begin
                case (step)
                    PH_IDLE: s = arm_wait(s, 1'b1, PH_1);
                    PH_1: begin
                        s.level = 1'b0;
                        s = arm_wait(s, 1'b1, PH_2);
                    end
                    PH_2: begin
                        s.scl = 1'b0;
                        s = arm_wait(s, 1'b0, PH_3);
                    end
                    default: s = end_cmd(s);
                endcase
            end
            OP_STOP: begin
                case (step)
                    PH_IDLE: begin
                        s.level = 1'b0;
                        s = arm_wait(s, 1'b0, PH_1);
                    end
                    PH_1: begin
                        s.scl = 1'b1;
                        s = arm_wait(s, 1'b1, PH_2);
                    end
                    PH_2: begin
                        s.level = 1'b1;
                        s = arm_wait(s, 1'b1, PH_3);
                    end
                    default: s = end_cmd(s);
                endcase
            end
            OP_WRITE: begin
                if (step == PH_IDLE) begin
                    s.bits  = '0;
                    s.shift = wd;
                    step    = PH_1;
                end
                // falling scl closes a data bit; after the last one go to the ack slot
                if (step == PH_3) begin
                    s.scl  = 1'b0;
                    s.bits = s.bits + 4'd1;
                    if (s.bits < BITS_PER_BYTE) begin
                        step = PH_1;
                    end else begin
                        s.drive = 1'b0;
                        s.level = 1'b1;
                        return arm_wait(s, 1'b0, PH_4);
                    end
                end
                case (step)
                    PH_1: begin
                        s.drive = 1'b1;
                        s.level = s.shift[7];
                        s.shift = s.shift << 1;
                        s = arm_wait(s, 1'b0, PH_2);
                    end
                    PH_2: begin
                        s.scl = 1'b1;
                        s = arm_wait(s, 1'b0, PH_3);
                    end
                    PH_4: begin
                        s.scl = 1'b1;
                        s = arm_wait(s, 1'b1, PH_5);
                    end
                    PH_5: begin
                        s.ack = sense;
                        s = arm_wait(s, 1'b1, PH_6);
                    end
                    PH_6: begin
                        s.scl = 1'b0;
                        s = arm_wait(s, 1'b0, PH_7);
                    end
                    default: begin
                        s.drive = 1'b1;
                        s = end_cmd(s);
                    end
                endcase
            end
            default: begin
                case (step)
                    PH_IDLE: begin
                        s.drive = 1'b0;
                        s.bits  = '0;
                        s.shift = '0;
                        s = arm_wait(s, 1'b0, PH_1);
                    end
                    PH_1: begin
                        s.scl = 1'b1;
                        s = arm_wait(s, 1'b1, PH_2);
                    end
                    PH_2: begin
                        s.shift = {s.shift[6:0], sense};
                        s = arm_wait(s, 1'b1, PH_3);
                    end
                    PH_3: begin
                        s.scl  = 1'b0;
                        s.bits = s.bits + 4'd1;
                        if (s.bits < BITS_PER_BYTE) begin
                            s = arm_wait(s, 1'b0, PH_1);
                        end else begin
                            // master acknowledges every byte it reads
                            s.drive = 1'b1;
                            s.level = 1'b0;
                            s = arm_wait(s, 1'b0, PH_4);
                        end
                    end
                    PH_4: begin
                        s.scl = 1'b1;
                        s = arm_wait(s, 1'b0, PH_5);
                    end
                    default: begin
                        s.scl     = 1'b0;
                        s.level   = 1'b1;
                        s.rd_hold = s.shift;
                        s = end_cmd(s);
                    end
                endcase
            end
        endcase
        return s;
    endfunction

    // one timebase tick: take a command when idle, otherwise count the wait
    function automatic bus_state_t tick_bus(bus_state_t s, logic [11:0] sd, logic [11:0] ld,
                                            logic [15:0] tick);
        logic [11:0] target;
        s.done = 1'b0;
        if (s.ph == PH_IDLE) begin
            if (tick[0]) begin
                s.aop = op_t'(tick[2:1]);
                s = run_pin_step(s, PH_IDLE, tick[11], tick[10:3]);
            end
        end else begin
            target = s.wlong ? ld : sd;
            if (s.cnt != DLY_MAX)
                s.cnt = s.cnt + 12'd1;
            if (s.cnt >= target)
                s = run_pin_step(s, s.ph, tick[11], tick[10:3]);
        end
        return s;
    endfunction

    function automatic pin_word_t pins_of(bus_state_t s);
        pin_word_t w;
        w.scl   = s.scl;
        w.drive = s.drive;
        w.level = s.level;
        w.busy  = (s.ph != PH_IDLE);
        w.done  = s.done;
        w.ack   = s.ack;
        w.rd    = s.rd_hold;
        return w;
    endfunction

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d actual %0d", fname, want, got);
            fail_count++;
        end
    endtask

    assign s_hs     = s_axis_tvalid && s_axis_tready;
    assign step_nxt = tick_bus(bus_st, short_dly, long_dly, s_axis_tdata);
    // busy after the tick now on the bus if it is taken at this edge
    assign busy_next = s_hs ? (step_nxt.ph != PH_IDLE) : (bus_st.ph != PH_IDLE);

    // track config, predict on each tick transaction, compare each result transaction
    always @(posedge aclk) begin
        pin_word_t want;
        if (!aresetn) begin
            bus_st    <= BUS_RESET;
            short_dly <= 12'd2;
            long_dly  <= 12'd4;
            expected_pins_q.delete();
            pending   <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_SHORT_DELAY)
                    short_dly <= cfg_wdata;
                else
                    long_dly <= cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pins_q.size() == 0) begin
                    $error("result transaction with no expected pin word");
                    fail_count++;
                end else begin
                    want = expected_pins_q.pop_front();
                    check_field("scl_level", want.scl, m_axis_tdata[0]);
                    check_field("sda_drive", want.drive, m_axis_tdata[1]);
                    check_field("sda_level", want.level, m_axis_tdata[2]);
                    check_field("busy_res", want.busy, m_axis_tdata[3]);
                    check_field("done_res", want.done, m_axis_tdata[4]);
                    check_field("ack_missing", want.ack, m_axis_tdata[5]);
                    check_field("read_data", want.rd, m_axis_tdata[13:6]);
                end
            end
            if (s_hs) begin
                bus_st <= step_nxt;
                expected_pins_q.push_back(pins_of(step_nxt));
            end
            pending <= expected_pins_q.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for i2c_bit_master_unit
// depends on i2cbm_pkg, i2c_bit_master_unit and i2cbm_checker

module tb_top;
    import i2cbm_pkg::*;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [0] command_valid, [2:1] operation, [10:3] write_data, [11] sda_sense
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] scl_level, [1] sda_drive, [2] sda_level, [3] busy_res,
    // [4] done_res, [5] ack_missing, [13:6] read_data
    logic [15:0] m_axis_tdata;
    logic        cfg_we        = 1'b0;
    logic        cfg_addr      = REG_SHORT_DELAY;
    logic [11:0] cfg_wdata     = '0;

    logic        busy_next;
    int          pending;
    int          fail_count;
    int          tick_cnt   = 0;
    int          stall_left = 0;
    bit          gaps_on    = 1'b1;
    bit          stalls_on  = 1'b1;

    localparam int SENSE_LOW  = 0;
    localparam int SENSE_HIGH = 1;
    localparam int SENSE_RAND = 2;

    i2c_bit_master_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    i2cbm_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .busy_next     (busy_next),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic pick_sense(int mode);
        if (mode == SENSE_LOW)
            return 1'b0;
        else if (mode == SENSE_HIGH)
            return 1'b1;
        else
            return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [11:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 12'($urandom_range(1, 4));
        else
            return 12'($urandom_range(5, 12));
    endfunction

    // result side: ready with random stalls
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 15)
                stall_left <= (pick_gap() == 0) ? $urandom_range(1, 2) : pick_gap() + 1;
        end
    end

    // offer one tick and wait for its transaction
    task automatic send_tick(logic valid, op_t op, logic [7:0] wd, logic sense);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, sense, wd, op, valid};
        do @(posedge aclk); while (!s_axis_tready);
        tick_cnt++;
    endtask

    // issue a command and keep ticking until it completes; commands offered
    // meanwhile must be ignored
    task automatic run_cmd(op_t op, logic [7:0] wd, int sense_mode);
        send_tick(1'b1, op, wd, pick_sense(sense_mode));
        while (busy_next)
            send_tick(1'($urandom_range(0, 1)), op_t'(2'($urandom_range(0, 3))),
                      8'($urandom_range(0, 255)), pick_sense(sense_mode));
    endtask

    task automatic idle_ticks(int n);
        repeat (n)
            send_tick(1'b0, op_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    // hold off until every result is back, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_delays(logic [11:0] sd, logic [11:0] ld);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_SHORT_DELAY;
        cfg_wdata <= sd;
        @(posedge aclk);
        cfg_addr  <= REG_LONG_DELAY;
        cfg_wdata <= ld;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin
        int r;
        int n;
        int rand_goal;
        int next_cfg;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: read with no prior drive, stop right after start
        run_cmd(OP_READ, 8'h00, SENSE_RAND);
        run_cmd(OP_START, 8'h00, SENSE_RAND);
        run_cmd(OP_STOP, 8'h00, SENSE_RAND);
        // full byte extremes, missing and present ack, read all ones and zeros
        run_cmd(OP_START, 8'hFF, SENSE_RAND);
        run_cmd(OP_WRITE, 8'hFF, SENSE_HIGH);
        run_cmd(OP_WRITE, 8'h00, SENSE_LOW);
        run_cmd(OP_WRITE, 8'hA5, SENSE_RAND);
        run_cmd(OP_READ, 8'h5A, SENSE_HIGH);
        run_cmd(OP_READ, 8'hFF, SENSE_LOW);
        run_cmd(OP_READ, 8'h00, SENSE_RAND);
        run_cmd(OP_STOP, 8'h00, SENSE_RAND);
        idle_ticks(3);

        // zero short delay behaves as one tick
        set_delays(12'd0, 12'd1);
        run_cmd(OP_START, 8'h00, SENSE_RAND);
        run_cmd(OP_WRITE, 8'h3C, SENSE_RAND);
        run_cmd(OP_READ, 8'h00, SENSE_RAND);
        run_cmd(OP_STOP, 8'h00, SENSE_RAND);

        // long delays, no idling so the run stays short
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_delays(12'd30, 12'd50);
        run_cmd(OP_STOP, 8'h00, SENSE_RAND);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // random part: mostly framed transfers, some loose commands and idle ticks
        rand_goal = tick_cnt + 650;
        next_cfg  = tick_cnt;
        while (tick_cnt < rand_goal) begin
            if (tick_cnt >= next_cfg) begin
                set_delays(pick_delay(), pick_delay());
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
                next_cfg  = tick_cnt + $urandom_range(200, 350);
            end
            r = $urandom_range(0, 99);
            if (r < 80) begin
                run_cmd(OP_START, 8'($urandom_range(0, 255)), SENSE_RAND);
                n = $urandom_range(1, 3);
                repeat (n) begin
                    if ($urandom_range(0, 1))
                        run_cmd(OP_WRITE, 8'($urandom_range(0, 255)), SENSE_RAND);
                    else
                        run_cmd(OP_READ, 8'($urandom_range(0, 255)), SENSE_RAND);
                end
                run_cmd(OP_STOP, 8'($urandom_range(0, 255)), SENSE_RAND);
            end else if (r < 92) begin
                run_cmd(op_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                        SENSE_RAND);
            end else begin
                idle_ticks($urandom_range(1, 4));
            end
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end

        // drain and report
        wait_drained();
        repeat (5) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // run time limit
    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
